// File: rtl/plps_pkg.sv
package plps_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 240;
   localparam int SCREEN_HEIGHT_DEFAULT = 160;

   localparam int QUEUE_DEPTH = 2;
   localparam int MAX_LAYERS  = 6;
   localparam int CSR_WIDTH   = 32;

   localparam logic [2:0] LAYER_SPRITE   = 3'd4;
   localparam logic [2:0] LAYER_BACKDROP = 3'd5;

   localparam logic [2:0] CSR_DISPLAY_CONTROL  = 3'd0;
   localparam logic [2:0] CSR_BLEND_TARGETS    = 3'd1;
   localparam logic [2:0] CSR_WINDOW_ENABLES   = 3'd2;
   localparam logic [2:0] CSR_WINDOW0_BOUNDS   = 3'd3;
   localparam logic [2:0] CSR_WINDOW1_BOUNDS   = 3'd4;
   localparam logic [2:0] CSR_BG_PRIORITIES    = 3'd5;

   typedef enum logic [2:0] {
      REGION_OFF     = 3'd0,
      REGION_WIN0    = 3'd1,
      REGION_WIN1    = 3'd2,
      REGION_OBJWIN  = 3'd3,
      REGION_OUTSIDE = 3'd4
   } plps_region_type;

   typedef struct packed {
      logic [10:0] display_control;
      logic [11:0] blend_targets;
      logic [23:0] window_layer_enables;
      logic [31:0] window0_bounds;
      logic [31:0] window1_bounds;
      logic [7:0]  bg_priorities;
   } plps_cfg_type;

   typedef struct packed {
      logic [7:0]       pixel_x;
      logic [7:0]       line_y;
      logic [3:0][14:0] bg_color;
      logic [14:0]      sprite_color;
      logic [4:0]       layer_opaque;
      logic [1:0]       sprite_priority;
      logic             sprite_semitransparent;
      logic             sprite_window;
      logic [14:0]      backdrop_color;
   } plps_pixel_type;

   typedef struct packed {
      logic [MAX_LAYERS-1:0][2:0]  ids;
      logic [MAX_LAYERS-1:0][14:0] cols;
      logic [2:0]                  last_idx;
      plps_region_type             region;
      logic                        effects;
      logic                        single_found;
      logic [14:0]                 single_color;
      logic                        pair_found;
      logic [14:0]                 first_color;
      logic [14:0]                 second_color;
   } plps_entry_type;

   typedef struct packed {
      logic [14:0]     layer_color;
      logic [2:0]      layer_id;
      logic            is_last;
      plps_region_type window_region;
      logic            effects_enabled;
      logic            single_target_found;
      logic [14:0]     single_target_color;
      logic            pair_found;
      logic [14:0]     first_target_color;
      logic [14:0]     second_target_color;
   } plps_result_type;

   // bit 4 sprite, bits 3:0 bg0..bg3
   function automatic logic [4:0] mode_mask(input logic [10:0] dc);
      logic [3:0] m;
      case (dc[2:0])
         3'd0: m = 4'hF;
         3'd1: m = 4'h7;
         3'd2: m = 4'hC;
         3'd3, 3'd4, 3'd5: m = 4'h4;
         default: m = 4'h0;
      endcase
      return {dc[7], m & dc[6:3]};
   endfunction

endpackage

// File: rtl/plps_front.sv
module plps_front #(
   parameter int SCREEN_WIDTH  = plps_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = plps_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  plps_pkg::plps_pixel_type pixel,
   input  plps_pkg::plps_cfg_type   cfg,
   input  logic                     queue_full,
   output logic                     busy,
   output logic                     push,
   output plps_pkg::plps_entry_type entry
);

   localparam logic [7:0] XLimit = 8'(SCREEN_WIDTH);
   localparam logic [7:0] YLimit = 8'(SCREEN_HEIGHT);

   logic                     stage_valid_ff, stage_valid_in;
   plps_pkg::plps_pixel_type stage_ff, stage_in;
   logic                     accept;

   logic                     in_w0, in_w1;
   plps_pkg::plps_region_type region;
   logic [5:0]               grp;
   logic [4:0]               wmask, vis;
   logic [4:0][4:0]          key;
   logic [4:0][2:0]          pos;
   logic [4:0][14:0]         col;
   logic [2:0]               nvis;
   logic [5:0]               a_mask, b_mask, am;

   function automatic logic in_window(input logic [31:0] b, input logic [7:0] px,
                                      input logic [7:0] py);
      logic [7:0] x1;
      logic [7:0] y1;
      x1 = b[15:8];
      y1 = b[31:24];
      if (x1 > XLimit || x1 < b[7:0]) x1 = XLimit;
      if (y1 > YLimit || y1 < b[23:16]) y1 = YLimit;
      return px >= b[7:0] && px < x1 && py >= b[23:16] && py < y1;
   endfunction

   assign busy   = stage_valid_ff && queue_full;
   assign push   = stage_valid_ff && !queue_full;
   assign accept = start && !busy;

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !push);
      stage_in       = accept ? pixel : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   // classify the held pixel
   always_comb begin
      in_w0 = in_window(cfg.window0_bounds, stage_ff.pixel_x, stage_ff.line_y);
      in_w1 = in_window(cfg.window1_bounds, stage_ff.pixel_x, stage_ff.line_y);
      if (cfg.display_control[10:8] == 3'b000) begin
         region = plps_pkg::REGION_OFF;
      end else if (cfg.display_control[8] && in_w0) begin
         region = plps_pkg::REGION_WIN0;
      end else if (cfg.display_control[9] && in_w1) begin
         region = plps_pkg::REGION_WIN1;
      end else if (cfg.display_control[10] && stage_ff.sprite_window
                   && stage_ff.layer_opaque[4]) begin
         region = plps_pkg::REGION_OBJWIN;
      end else begin
         region = plps_pkg::REGION_OUTSIDE;
      end

      case (region)
         plps_pkg::REGION_WIN0:    grp = cfg.window_layer_enables[5:0];
         plps_pkg::REGION_WIN1:    grp = cfg.window_layer_enables[11:6];
         plps_pkg::REGION_OBJWIN:  grp = cfg.window_layer_enables[17:12];
         plps_pkg::REGION_OUTSIDE: grp = cfg.window_layer_enables[23:18];
         default:                  grp = 6'h3F;
      endcase
      wmask = grp[4:0];
      vis   = plps_pkg::mode_mask(cfg.display_control) & wmask & stage_ff.layer_opaque;

      // sort key: priority, then sprite ahead of bg0..bg3
      for (int l = 0; l < 4; l++) begin
         key[l] = {cfg.bg_priorities[2*l +: 2], 3'(l + 1)};
         col[l] = stage_ff.bg_color[l];
      end
      key[4] = {stage_ff.sprite_priority, 3'd0};
      col[4] = stage_ff.sprite_color;

      for (int l = 0; l < 5; l++) begin
         pos[l] = 3'd0;
         for (int m = 0; m < 5; m++) begin
            pos[l] = pos[l] + 3'(vis[m] && (key[m] < key[l]));
         end
      end
      nvis = 3'($countones(vis));

      entry = '0;
      for (int l = 0; l < 5; l++) begin
         if (vis[l]) begin
            entry.ids[pos[l]]  = 3'(l);
            entry.cols[pos[l]] = col[l];
         end
      end
      entry.ids[nvis]  = plps_pkg::LAYER_BACKDROP;
      entry.cols[nvis] = stage_ff.backdrop_color;
      entry.last_idx   = nvis;
      entry.region     = region;
      entry.effects    = grp[5];

      a_mask = cfg.blend_targets[5:0];
      b_mask = cfg.blend_targets[11:6];
      am     = stage_ff.sprite_semitransparent ? 6'b010000 : a_mask;

      if (stage_ff.sprite_semitransparent) begin
         entry.single_found = vis[4];
         entry.single_color = vis[4] ? stage_ff.sprite_color : 15'd0;
      end else begin
         entry.single_found = a_mask[entry.ids[0]];
         entry.single_color = a_mask[entry.ids[0]] ? entry.cols[0] : 15'd0;
      end

      entry.pair_found   = (nvis != 3'd0) && am[entry.ids[0]] && b_mask[entry.ids[1]];
      entry.first_color  = entry.pair_found ? entry.cols[0] : 15'd0;
      entry.second_color = entry.pair_found ? entry.cols[1] : 15'd0;
   end

endmodule

// File: rtl/plps_queue.sv
module plps_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  plps_pkg::plps_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output plps_pkg::plps_entry_type head
);

   localparam int Depth      = plps_pkg::QUEUE_DEPTH;
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);

   plps_pkg::plps_entry_type entries_ff [Depth];
   logic [PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = (count_ff == CountFull);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/plps_back.sv
module plps_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      empty,
   input  plps_pkg::plps_entry_type  head,
   output logic                      pop,
   output logic                      rsp_strobe,
   output plps_pkg::plps_result_type rsp
);

   logic [2:0]                idx_ff, idx_in;
   logic                      strobe_ff, strobe_in;
   plps_pkg::plps_result_type rsp_ff, rsp_in;
   logic                      last;

   assign last = (idx_ff == head.last_idx);
   assign pop  = !empty && last;

   always_comb begin
      strobe_in = !empty;
      idx_in    = idx_ff;
      if (!empty) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
      rsp_in.layer_color         = head.cols[idx_ff];
      rsp_in.layer_id            = head.ids[idx_ff];
      rsp_in.is_last             = last;
      rsp_in.window_region       = head.region;
      rsp_in.effects_enabled     = head.effects;
      rsp_in.single_target_found = head.single_found;
      rsp_in.single_target_color = head.single_color;
      rsp_in.pair_found          = head.pair_found;
      rsp_in.first_target_color  = head.first_color;
      rsp_in.second_target_color = head.second_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= 3'd0;
         strobe_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// File: rtl/pixel_layer_priority_window_select_unit.sv
// Flow: the first result of a pixel passes the input stage, the queue and the output
// register; the rest follow in consecutive cycles, one per listed layer.
// A pixel gives n results (1 to 6) and holds the output serializer until its last;
// accepting stops only while the stage holds a pixel and the two-entry queue is full.
// Reset (synchronous, active high) zeroes the configuration and empties the stage and queue.
// The receiver cannot stall: every strobed result is taken in its cycle.
module pixel_layer_priority_window_select_unit #(
   parameter int SCREEN_WIDTH  = plps_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = plps_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_line_y,
   input  logic [14:0] req_bg0_color,
   input  logic [14:0] req_bg1_color,
   input  logic [14:0] req_bg2_color,
   input  logic [14:0] req_bg3_color,
   input  logic [14:0] req_sprite_color,
   input  logic [4:0]  req_layer_opaque,
   input  logic [1:0]  req_sprite_priority,
   input  logic        req_sprite_semitransparent,
   input  logic        req_sprite_window,
   input  logic [14:0] req_backdrop_color,
   output logic        rsp_strobe,
   output logic [14:0] rsp_layer_color,
   output logic [2:0]  rsp_layer_id,
   output logic        rsp_is_last,
   output logic [2:0]  rsp_window_region,
   output logic        rsp_effects_enabled,
   output logic        rsp_single_target_found,
   output logic [14:0] rsp_single_target_color,
   output logic        rsp_pair_found,
   output logic [14:0] rsp_first_target_color,
   output logic [14:0] rsp_second_target_color,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [plps_pkg::CSR_WIDTH-1:0] csr_write_data
);

   plps_pkg::plps_cfg_type    cfg_ff, cfg_in;
   plps_pkg::plps_pixel_type  pixel;
   plps_pkg::plps_entry_type  front_entry, head;
   plps_pkg::plps_result_type rsp;
   logic                      push, pop, queue_full, queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            plps_pkg::CSR_DISPLAY_CONTROL: cfg_in.display_control = csr_write_data[10:0];
            plps_pkg::CSR_BLEND_TARGETS:   cfg_in.blend_targets   = csr_write_data[11:0];
            plps_pkg::CSR_WINDOW_ENABLES:
               cfg_in.window_layer_enables = csr_write_data[23:0];
            plps_pkg::CSR_WINDOW0_BOUNDS:  cfg_in.window0_bounds  = csr_write_data;
            plps_pkg::CSR_WINDOW1_BOUNDS:  cfg_in.window1_bounds  = csr_write_data;
            plps_pkg::CSR_BG_PRIORITIES:   cfg_in.bg_priorities   = csr_write_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      pixel.pixel_x                = req_pixel_x;
      pixel.line_y                 = req_line_y;
      pixel.bg_color[0]            = req_bg0_color;
      pixel.bg_color[1]            = req_bg1_color;
      pixel.bg_color[2]            = req_bg2_color;
      pixel.bg_color[3]            = req_bg3_color;
      pixel.sprite_color           = req_sprite_color;
      pixel.layer_opaque           = req_layer_opaque;
      pixel.sprite_priority        = req_sprite_priority;
      pixel.sprite_semitransparent = req_sprite_semitransparent;
      pixel.sprite_window          = req_sprite_window;
      pixel.backdrop_color         = req_backdrop_color;
   end

   plps_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .pixel      (pixel),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .entry      (front_entry)
   );

   plps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   plps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_layer_color         = rsp.layer_color;
   assign rsp_layer_id            = rsp.layer_id;
   assign rsp_is_last             = rsp.is_last;
   assign rsp_window_region       = rsp.window_region;
   assign rsp_effects_enabled     = rsp.effects_enabled;
   assign rsp_single_target_found = rsp.single_target_found;
   assign rsp_single_target_color = rsp.single_target_color;
   assign rsp_pair_found          = rsp.pair_found;
   assign rsp_first_target_color  = rsp.first_target_color;
   assign rsp_second_target_color = rsp.second_target_color;

   // the backdrop closes every pixel's list, and only it
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_last == (rsp_layer_id == plps_pkg::LAYER_BACKDROP)))
      else $error("backdrop and end-of-list mark disagree");

   // a pixel's results go out in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_last |=> rsp_strobe)
      else $error("gap inside a pixel's result list");

   // per-pixel fields hold across the list
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_last |=> $stable(rsp_window_region)
         && $stable(rsp_pair_found) && $stable(rsp_single_target_color))
      else $error("per-pixel fields changed within a list");

   // the front only stalls when the queue is full
   assert property (@(posedge clock) disable iff (reset)
      busy |-> queue_full && !push)
      else $error("busy without a full queue");

endmodule
